// ----- src/ikl_pkg.sv -----
`default_nettype none

package ikl_pkg;

    localparam int CORDIC_STAGES  = 16;
    localparam int ATAN_TABLE_LEN = 24;
    localparam int CORDIC_USED    = (CORDIC_STAGES < ATAN_TABLE_LEN) ?
                                    CORDIC_STAGES : ATAN_TABLE_LEN;

    localparam int SQRT_D_STEPS = 24;
    localparam int SQRT_C_STEPS = 17;
    localparam int DIV_STEPS    = 18;
    localparam int ACOS_LAT     = DIV_STEPS + SQRT_C_STEPS + CORDIC_USED + 4;
    localparam int PIPE_LEN     = SQRT_D_STEPS + 4 + ACOS_LAT;

    localparam logic [1:0] REG_UPPER = 2'd0;
    localparam logic [1:0] REG_LOWER = 2'd1;
    localparam logic [1:0] REG_REACH = 2'd2;

    localparam logic [14:0] UPPER_RESET = 15'd7040;
    localparam logic [14:0] LOWER_RESET = 15'd8320;
    localparam logic [15:0] REACH_RESET = 16'd15040;

    localparam logic signed [26:0] DEG90  = 27'sd5898240;
    localparam logic signed [26:0] DEG180 = 27'sd11796480;
    localparam logic [16:0]        ONE_Q16 = 17'd65536;

    typedef struct packed {
        logic [47:0] rad;
        logic [23:0] root;
        logic [25:0] rem;
    } sqrt_t;

    typedef struct packed {
        logic [39:0] rem;
        logic [39:0] den;
        logic [17:0] quo;
        logic        neg;
        logic        sat;
    } div_t;

    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [26:0] ang;
    } cordic_t;

    function automatic logic signed [26:0] atan_entry(input logic [4:0] idx);
        logic signed [26:0] v;
        unique case (idx)
            5'd0:    v = 27'sd2949120;
            5'd1:    v = 27'sd1740967;
            5'd2:    v = 27'sd919879;
            5'd3:    v = 27'sd466945;
            5'd4:    v = 27'sd234379;
            5'd5:    v = 27'sd117304;
            5'd6:    v = 27'sd58666;
            5'd7:    v = 27'sd29335;
            5'd8:    v = 27'sd14668;
            5'd9:    v = 27'sd7334;
            5'd10:   v = 27'sd3667;
            5'd11:   v = 27'sd1833;
            5'd12:   v = 27'sd917;
            5'd13:   v = 27'sd458;
            5'd14:   v = 27'sd229;
            5'd15:   v = 27'sd115;
            5'd16:   v = 27'sd57;
            5'd17:   v = 27'sd29;
            5'd18:   v = 27'sd14;
            5'd19:   v = 27'sd7;
            5'd20:   v = 27'sd4;
            5'd21:   v = 27'sd2;
            5'd22:   v = 27'sd1;
            default: v = 27'sd0;
        endcase
        return v;
    endfunction

    // Scales both operands by 2^14 and brings a left half-plane vector
    // into the right half-plane by a quarter turn.
    function automatic cordic_t cordic_prerotate(input logic signed [17:0] y,
                                                 input logic signed [17:0] x);
        logic signed [33:0] xs;
        logic signed [33:0] ys;
        cordic_t r;
        xs = {{2{x[17]}}, x, 14'b0};
        ys = {{2{y[17]}}, y, 14'b0};
        if (x[17]) begin
            if (!y[17]) begin
                r.x   = ys;
                r.y   = -xs;
                r.ang = DEG90;
            end
            else begin
                r.x   = -ys;
                r.y   = xs;
                r.ang = -DEG90;
            end
        end
        else begin
            r.x   = xs;
            r.y   = ys;
            r.ang = '0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- src/ikl_if.sv -----
`default_nettype none

interface ikl_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] target_forward;
    logic signed [15:0] target_down;

    modport source (output valid, output target_forward, output target_down, input ready);
    modport sink   (input valid, input target_forward, input target_down, output ready);
endinterface

interface ikl_out_if;
    logic               valid;
    logic               ready;
    logic               reachable;
    logic signed [15:0] upper_joint_angle;
    logic [13:0]        knee_joint_angle;

    modport source (output valid, output reachable, output upper_joint_angle,
                    output knee_joint_angle, input ready);
    modport sink   (input valid, input reachable, input upper_joint_angle,
                    input knee_joint_angle, output ready);
endinterface

interface ikl_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- src/ikl_sqrt_cell.sv -----
`default_nettype none

module ikl_sqrt_cell (
    input  logic           clk,
    input  logic           en,
    input  ikl_pkg::sqrt_t d_in,
    output ikl_pkg::sqrt_t d_out
);

    ikl_pkg::sqrt_t d_reg;
    ikl_pkg::sqrt_t d_next;
    logic [27:0]    rem_sh;
    logic [27:0]    trial;

    always_comb
    begin
        rem_sh     = {d_in.rem, d_in.rad[47:46]};
        trial      = {2'b00, d_in.root, 2'b01};
        d_next.rad = {d_in.rad[45:0], 2'b00};
        if (rem_sh >= trial)
        begin
            d_next.rem  = 26'(rem_sh - trial);
            d_next.root = {d_in.root[22:0], 1'b1};
        end
        else
        begin
            d_next.rem  = rem_sh[25:0];
            d_next.root = {d_in.root[22:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;

endmodule

`default_nettype wire

// ----- src/ikl_div_cell.sv -----
`default_nettype none

module ikl_div_cell (
    input  logic          clk,
    input  logic          en,
    input  ikl_pkg::div_t d_in,
    output ikl_pkg::div_t d_out
);

    ikl_pkg::div_t d_reg;
    ikl_pkg::div_t d_next;
    logic [40:0]   sh;
    logic [40:0]   dd;

    always_comb
    begin
        sh     = {d_in.rem, 1'b0};
        dd     = {1'b0, d_in.den};
        d_next = d_in;
        if (sh >= dd)
        begin
            d_next.rem = 40'(sh - dd);
            d_next.quo = {d_in.quo[16:0], 1'b1};
        end
        else
        begin
            d_next.rem = sh[39:0];
            d_next.quo = {d_in.quo[16:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;

endmodule

`default_nettype wire

// ----- src/ikl_cordic_cell.sv -----
`default_nettype none

module ikl_cordic_cell (
    input  logic             clk,
    input  logic             en,
    input  logic [4:0]       stage,
    input  ikl_pkg::cordic_t d_in,
    output ikl_pkg::cordic_t d_out
);

    ikl_pkg::cordic_t   d_reg;
    ikl_pkg::cordic_t   d_next;
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic signed [26:0] step;

    always_comb
    begin
        dx   = d_in.y >>> stage;
        dy   = d_in.x >>> stage;
        step = ikl_pkg::atan_entry(stage);
        if (d_in.y > 34'sd0)
        begin
            d_next.x   = d_in.x + dx;
            d_next.y   = d_in.y - dy;
            d_next.ang = d_in.ang + step;
        end
        else
        begin
            d_next.x   = d_in.x - dx;
            d_next.y   = d_in.y + dy;
            d_next.ang = d_in.ang - step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;

endmodule

`default_nettype wire

// ----- src/ikl_acos.sv -----
`default_nettype none

module ikl_acos (
    input  logic               clk,
    input  logic               en,
    input  logic signed [33:0] num,
    input  logic [39:0]        den,
    output logic signed [26:0] angle
);

    localparam int DS = ikl_pkg::DIV_STEPS;
    localparam int SS = ikl_pkg::SQRT_C_STEPS;
    localparam int CS = ikl_pkg::CORDIC_USED;

    logic [33:0]        mag;
    ikl_pkg::div_t      div_next;
    ikl_pkg::div_t      div_link [DS+1];
    logic [17:0]        quo;
    logic [16:0]        qc;
    logic signed [17:0] c_next;
    logic signed [17:0] c_reg;
    logic signed [35:0] csq;
    logic [33:0]        v_reg;
    logic signed [17:0] c2_reg;
    logic signed [17:0] c_dl_reg [SS];
    ikl_pkg::sqrt_t     sq_link [SS+1];
    ikl_pkg::cordic_t   cp_reg;
    ikl_pkg::cordic_t   cr_link [CS+1];
    ikl_pkg::div_t      div_reg;

    always_comb
    begin
        mag           = num[33] ? 34'(-num) : 34'(num);
        div_next.neg  = num[33];
        div_next.rem  = {1'b0, mag[32:0], 6'b0};
        div_next.sat  = ({1'b0, mag[32:0], 6'b0} >= den);
        div_next.den  = den;
        div_next.quo  = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            div_reg <= div_next;
        end
    end

    assign div_link[0] = div_reg;

    for (genvar k = 0; k < DS; k++)
    begin : g_div
        ikl_div_cell u_cell (
            .clk   (clk),
            .en    (en),
            .d_in  (div_link[k]),
            .d_out (div_link[k+1])
        );
    end

    always_comb
    begin
        quo = div_link[DS].quo;
        if (div_link[DS].sat || (quo > 18'(ikl_pkg::ONE_Q16)))
        begin
            qc = ikl_pkg::ONE_Q16;
        end
        else
        begin
            qc = quo[16:0];
        end
        c_next = div_link[DS].neg ? 18'(-{1'b0, qc}) : {1'b0, qc};
    end

    assign csq = c_reg * c_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_reg       <= c_next;
            v_reg       <= 34'(36'sh1_0000_0000 - csq);
            c2_reg      <= c_reg;
            c_dl_reg[0] <= c2_reg;
            for (int i = 1; i < SS; i++)
            begin
                c_dl_reg[i] <= c_dl_reg[i-1];
            end
        end
    end

    assign sq_link[0] = '{rad: {v_reg, 14'b0}, root: '0, rem: '0};

    for (genvar k = 0; k < SS; k++)
    begin : g_sqrt
        ikl_sqrt_cell u_cell (
            .clk   (clk),
            .en    (en),
            .d_in  (sq_link[k]),
            .d_out (sq_link[k+1])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cp_reg <= ikl_pkg::cordic_prerotate({1'b0, sq_link[SS].root[16:0]},
                                                c_dl_reg[SS-1]);
        end
    end

    assign cr_link[0] = cp_reg;

    for (genvar k = 0; k < CS; k++)
    begin : g_cordic
        ikl_cordic_cell u_cell (
            .clk   (clk),
            .en    (en),
            .stage (5'(k)),
            .d_in  (cr_link[k]),
            .d_out (cr_link[k+1])
        );
    end

    assign angle = cr_link[CS].ang;

endmodule

`default_nettype wire

// ----- src/two_link_leg_inverse_kinematics_core.sv -----
// Two-link leg inverse kinematics. Each target beat (forward and downward
// foot offset from the hip, 1/64 mm) yields one result beat with the
// reachable flag and the upper and knee joint angles in 1/64 degree, both
// zero for a target outside the reach band. The core is one deep pipeline
// of small cells (square-root, divider and CORDIC steps) and takes a new
// beat every clock cycle while results are taken; each result's path runs
// through the distance square root feeding the hip divider, the cosine
// square root and the CORDIC chain in series. While a finished result is
// not taken the whole pipeline holds. The three configuration registers
// are written through the cfg channel, which is always ready, and must
// only change while no target is in flight.
`default_nettype none

module two_link_leg_inverse_kinematics_core (
    input  logic              clk,
    input  logic              rst_n,
    ikl_in_if.sink            target,
    ikl_out_if.source         result,
    ikl_cfg_if.sink           cfg
);

    localparam int PL  = ikl_pkg::PIPE_LEN;
    localparam int SD  = ikl_pkg::SQRT_D_STEPS;
    localparam int CS  = ikl_pkg::CORDIC_USED;
    localparam int LA  = ikl_pkg::ACOS_LAT;
    localparam int KD  = SD + 1;
    localparam int TD  = SD + LA - CS;
    localparam int OKD = SD + 1 + LA;

    logic [14:0]        upper_reg;
    logic [14:0]        lower_reg;
    logic [15:0]        reach_reg;
    logic [15:0]        band_reg;
    logic [29:0]        uu_reg;
    logic [29:0]        tt_reg;
    logic [30:0]        ut2_reg;
    logic [31:0]        rr_reg;
    logic [30:0]        bb_reg;

    logic               en;
    logic [PL-1:0]      vld_reg;
    logic               out_valid_reg;
    logic               out_reach_reg;
    logic signed [15:0] out_upper_reg;
    logic [13:0]        out_knee_reg;

    logic signed [15:0] x1_reg;
    logic signed [15:0] z1_reg;
    logic signed [31:0] xsq;
    logic signed [31:0] zsq;
    logic [30:0]        xx2_reg;
    logic [30:0]        zz2_reg;
    logic signed [15:0] x2_reg;
    logic signed [15:0] z2_reg;
    logic [31:0]        d2_3_reg;
    logic signed [15:0] x3_reg;
    logic signed [15:0] z3_reg;

    logic               ok_3;
    logic signed [33:0] num_k;
    logic [31:0]        d2_dl_reg [SD];
    ikl_pkg::sqrt_t     sq_link [SD+1];
    logic signed [33:0] numa_reg;
    logic [39:0]        dena_reg;
    logic [39:0]        dena_next;

    logic signed [26:0] ang_a;
    logic signed [26:0] ang_k;
    logic signed [26:0] angk_dl_reg [KD];
    ikl_pkg::cordic_t   cpt_reg;
    ikl_pkg::cordic_t   ct_link [CS+1];
    logic signed [26:0] angt_dl_reg [TD];
    logic               ok_dl_reg [OKD];

    logic signed [26:0] upper_sum;
    logic signed [26:0] knee_sum;
    logic signed [26:0] upper_cl;
    logic signed [26:0] knee_cl;

    function automatic logic signed [26:0] to_out(input logic signed [26:0] a,
                                                  input logic signed [26:0] lo,
                                                  input logic signed [26:0] hi);
        logic signed [26:0] v;
        v = (a + 27'sd512) >>> 10;
        if (v < lo)
        begin
            v = lo;
        end
        if (v > hi)
        begin
            v = hi;
        end
        return v;
    endfunction

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_reg <= ikl_pkg::UPPER_RESET;
            lower_reg <= ikl_pkg::LOWER_RESET;
            reach_reg <= ikl_pkg::REACH_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                ikl_pkg::REG_UPPER: upper_reg <= cfg.data[14:0];
                ikl_pkg::REG_LOWER: lower_reg <= cfg.data[14:0];
                ikl_pkg::REG_REACH: reach_reg <= cfg.data;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        band_reg <= ((upper_reg > lower_reg) ? 16'(upper_reg - lower_reg)
                                             : 16'(lower_reg - upper_reg)) + 16'd64;
        uu_reg   <= 30'(upper_reg) * 30'(upper_reg);
        tt_reg   <= 30'(lower_reg) * 30'(lower_reg);
        ut2_reg  <= 31'({upper_reg, 1'b0}) * 31'(lower_reg);
        rr_reg   <= 32'(reach_reg) * 32'(reach_reg);
        bb_reg   <= 31'(band_reg) * 31'(band_reg);
    end

    assign en           = !out_valid_reg || result.ready;
    assign target.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[PL-2:0], target.valid};
            out_valid_reg <= vld_reg[PL-1];
        end
    end

    assign xsq = x1_reg * x1_reg;
    assign zsq = z1_reg * z1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg   <= target.target_forward;
            z1_reg   <= target.target_down;
            xx2_reg  <= xsq[30:0];
            zz2_reg  <= zsq[30:0];
            x2_reg   <= x1_reg;
            z2_reg   <= z1_reg;
            d2_3_reg <= 32'(xx2_reg) + 32'(zz2_reg);
            x3_reg   <= x2_reg;
            z3_reg   <= z2_reg;
        end
    end

    assign ok_3  = !((d2_3_reg > rr_reg) || (d2_3_reg < {1'b0, bb_reg}));
    assign num_k = signed'({4'b0, uu_reg}) + signed'({4'b0, tt_reg})
                 - signed'({2'b0, d2_3_reg});

    assign sq_link[0] = '{rad: {d2_3_reg, 16'b0}, root: '0, rem: '0};

    for (genvar k = 0; k < SD; k++)
    begin : g_dist
        ikl_sqrt_cell u_cell (
            .clk   (clk),
            .en    (en),
            .d_in  (sq_link[k]),
            .d_out (sq_link[k+1])
        );
    end

    assign dena_next = 40'({upper_reg, 1'b0}) * 40'(sq_link[SD].root);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d2_dl_reg[0] <= d2_3_reg;
            for (int i = 1; i < SD; i++)
            begin
                d2_dl_reg[i] <= d2_dl_reg[i-1];
            end
            numa_reg <= signed'({4'b0, uu_reg}) + signed'({2'b0, d2_dl_reg[SD-1]})
                      - signed'({4'b0, tt_reg});
            dena_reg <= dena_next;
            cpt_reg  <= ikl_pkg::cordic_prerotate({{2{z3_reg[15]}}, z3_reg},
                                                  {{2{x3_reg[15]}}, x3_reg});
        end
    end

    ikl_acos u_acos_hip (
        .clk   (clk),
        .en    (en),
        .num   (numa_reg),
        .den   (dena_reg),
        .angle (ang_a)
    );

    ikl_acos u_acos_knee (
        .clk   (clk),
        .en    (en),
        .num   (num_k),
        .den   ({1'b0, ut2_reg, 8'b0}),
        .angle (ang_k)
    );

    assign ct_link[0] = cpt_reg;

    for (genvar k = 0; k < CS; k++)
    begin : g_atan
        ikl_cordic_cell u_cell (
            .clk   (clk),
            .en    (en),
            .stage (5'(k)),
            .d_in  (ct_link[k]),
            .d_out (ct_link[k+1])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            angk_dl_reg[0] <= ang_k;
            for (int i = 1; i < KD; i++)
            begin
                angk_dl_reg[i] <= angk_dl_reg[i-1];
            end
            angt_dl_reg[0] <= ct_link[CS].ang;
            for (int i = 1; i < TD; i++)
            begin
                angt_dl_reg[i] <= angt_dl_reg[i-1];
            end
            ok_dl_reg[0] <= ok_3;
            for (int i = 1; i < OKD; i++)
            begin
                ok_dl_reg[i] <= ok_dl_reg[i-1];
            end
        end
    end

    assign upper_sum = angt_dl_reg[TD-1] + ang_a;
    assign knee_sum  = ikl_pkg::DEG180 - angk_dl_reg[KD-1];
    assign upper_cl  = to_out(upper_sum, -27'sd11520, 27'sd23040);
    assign knee_cl   = to_out(knee_sum, 27'sd0, 27'sd11520);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reach_reg <= ok_dl_reg[OKD-1];
            out_upper_reg <= ok_dl_reg[OKD-1] ? upper_cl[15:0] : 16'sd0;
            out_knee_reg  <= ok_dl_reg[OKD-1] ? knee_cl[13:0] : 14'd0;
        end
    end

    assign result.valid             = out_valid_reg;
    assign result.reachable         = out_reach_reg;
    assign result.upper_joint_angle = out_upper_reg;
    assign result.knee_joint_angle  = out_knee_reg;

endmodule

`default_nettype wire
